>>> src/u8dec_pkg.sv
// Package for the UTF-8 stream decoder: field widths, byte masks and the
// lead byte classification type.
// No dependencies.
package u8dec_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CP_W      = 21;
   localparam int unsigned PENDING_W = 2;

   localparam logic [BYTE_W-1:0] TERMINATOR   = 8'h00;
   localparam logic [BYTE_W-1:0] CONT_MASK    = 8'h3F;
   localparam logic [BYTE_W-1:0] ASCII_MASK   = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_CODE   = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK   = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK   = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_CODE   = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD2_BITS   = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_BITS   = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_BITS   = 8'h07;

   typedef enum logic [2:0] {
      LEAD_ASCII,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR,
      LEAD_INVALID
   } lead_class_type;

   function automatic lead_class_type classify_lead(input logic [BYTE_W-1:0] b);
      lead_class_type c;
      if ((b & ASCII_MASK) == TERMINATOR) begin
         c = LEAD_ASCII;
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         c = LEAD_TWO;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         c = LEAD_THREE;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         c = LEAD_FOUR;
      end else begin
         c = LEAD_INVALID;
      end
      return c;
   endfunction

endpackage

>>> src/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: input byte register, decode logic
// and code point result register.
// Depends on u8dec_pkg.

// The decoder takes one byte of UTF-8 text per cycle while the result side
// keeps up. The byte that completes a sequence passes the input byte register
// and is decoded against the open sequence state; the code point then lands in
// the output register, so a new byte is taken every cycle while the result
// side keeps up. Continuation bytes are not checked for their 10xxxxxx pattern,
// invalid lead bytes are dropped silently, and a zero byte ends the text,
// discarding any partial sequence without a result.
module utf8_stream_decoder_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [u8dec_pkg::BYTE_W-1:0] req_text_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [u8dec_pkg::CP_W-1:0]   rsp_code_point
);
   import u8dec_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]    in_byte_ff;
   logic [PENDING_W-1:0] pending_ff, pending_in;
   logic [CP_W-1:0]      partial_ff, partial_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CP_W-1:0]      out_cp_ff;
   logic                 accept, advance, emit;
   logic [CP_W-1:0]      emit_cp;
   logic [CP_W-1:0]      shifted;
   lead_class_type       lead_class;

   // The stored byte moves on when the result register is free or drains now.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;

   assign lead_class = classify_lead(in_byte_ff);
   assign shifted    = {partial_ff[CP_W-7:0], in_byte_ff[5:0] & CONT_MASK[5:0]};

   always_comb begin
      emit       = 1'b0;
      emit_cp    = shifted;
      pending_in = pending_ff;
      partial_in = partial_ff;
      if (in_byte_ff == TERMINATOR) begin
         pending_in = '0;
         partial_in = '0;
      end else if (pending_ff != '0) begin
         pending_in = pending_ff - PENDING_W'(1);
         if (pending_ff == PENDING_W'(1)) begin
            emit       = 1'b1;
            partial_in = '0;
         end else begin
            partial_in = shifted;
         end
      end else begin
         unique case (lead_class)
            LEAD_ASCII: begin
               emit    = 1'b1;
               emit_cp = CP_W'(in_byte_ff);
            end
            LEAD_TWO: begin
               partial_in = CP_W'(in_byte_ff & LEAD2_BITS);
               pending_in = PENDING_W'(1);
            end
            LEAD_THREE: begin
               partial_in = CP_W'(in_byte_ff & LEAD3_BITS);
               pending_in = PENDING_W'(2);
            end
            LEAD_FOUR: begin
               partial_in = CP_W'(in_byte_ff & LEAD4_BITS);
               pending_in = PENDING_W'(3);
            end
            default: begin
               // Invalid lead byte: dropped, state stays clear.
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = emit;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pending_ff   <= '0;
         partial_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_text_byte;
      end
      if (advance && emit) begin
         out_cp_ff <= emit_cp;
      end
   end

endmodule

>>> tb/utf8_stream_decoder_unit_test.sv
// Self-checking testbench for utf8_stream_decoder_unit: directed byte table, then random
// UTF-8 text, checked against a cycle-free decoding model kept inside this file.
// Depends on u8dec_pkg and utf8_stream_decoder_unit.
module utf8_stream_decoder_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import u8dec_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int LONG_HOLD     = 300;
   localparam int NUM_DIRECTED  = 25;
   localparam int DRAIN_CYCLES  = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              typed;
      logic              emits;
      logic [CP_W-1:0]   code_point;
   } directed_row_type;

   // Rows marked typed carry the expected result; the rest are left to the decoding model.
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{8'h00, 1'b1, 1'b0, 21'h0},        // terminator right after reset
      '{8'h01, 1'b1, 1'b1, 21'h01},
      '{8'h7F, 1'b1, 1'b1, 21'h7F},
      '{8'h80, 1'b1, 1'b0, 21'h0},        // stray continuation as lead is dropped
      '{8'hFF, 1'b1, 1'b0, 21'h0},        // lead above the four-byte form is dropped
      '{8'hC2, 1'b1, 1'b0, 21'h0},
      '{8'hA9, 1'b1, 1'b1, 21'h0000A9},
      '{8'hC0, 1'b1, 1'b0, 21'h0},        // overlong form decodes as it stands
      '{8'h80, 1'b1, 1'b1, 21'h0},
      '{8'hE2, 1'b0, 1'b0, 21'h0},
      '{8'h82, 1'b0, 1'b0, 21'h0},
      '{8'hAC, 1'b0, 1'b0, 21'h0},
      '{8'hEF, 1'b1, 1'b0, 21'h0},
      '{8'hBF, 1'b1, 1'b0, 21'h0},
      '{8'hBF, 1'b1, 1'b1, 21'h00FFFF},
      '{8'hF7, 1'b1, 1'b0, 21'h0},        // largest four-byte value
      '{8'hBF, 1'b1, 1'b0, 21'h0},
      '{8'hBF, 1'b1, 1'b0, 21'h0},
      '{8'hBF, 1'b1, 1'b1, 21'h1FFFFF},
      '{8'hF0, 1'b0, 1'b0, 21'h0},        // open sequence cut short by a terminator
      '{8'h41, 1'b0, 1'b0, 21'h0},
      '{8'h00, 1'b0, 1'b0, 21'h0},
      '{8'hE0, 1'b0, 1'b0, 21'h0},        // following bytes without the 10xxxxxx pattern
      '{8'hFF, 1'b0, 1'b0, 21'h0},
      '{8'hC0, 1'b0, 1'b0, 21'h0}
   };

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [BYTE_W-1:0] req_text_byte;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [CP_W-1:0]   rsp_code_point;

   // Decoder state as the testbench sees it.
   logic [PENDING_W-1:0] pend_count;
   logic [CP_W-1:0]      partial_cp;

   logic [CP_W-1:0] expected_code_points [$];

   int error_count;
   int bytes_sent;
   int decoded_items;
   int code_points_checked;
   int input_stall_cycles;
   int sender_gap_max;
   int rsp_gap_max;
   int result_wait_left;
   int hold_cycles_left;

   utf8_stream_decoder_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d code points still expected",
               CYCLE_LIMIT, expected_code_points.size());
      $display("Some tests failed");
      $finish;
   end

   // Advances the decoding model by one byte; returns 1 when a code point completes.
   function automatic bit decode_text_byte(input logic [BYTE_W-1:0] b,
                                           output logic [CP_W-1:0] cp);
      cp = '0;
      if (b == TERMINATOR) begin
         pend_count = '0;
         partial_cp = '0;
         return 1'b0;
      end
      if (pend_count != 0) begin
         partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
         pend_count = pend_count - PENDING_W'(1);
         if (pend_count == 0) begin
            cp = partial_cp;
            partial_cp = '0;
            return 1'b1;
         end
         return 1'b0;
      end
      casez (b)
         8'b0???????: begin
            cp = CP_W'(b);
            return 1'b1;
         end
         8'b110?????: begin
            partial_cp = CP_W'(b[4:0]);
            pend_count = 2'd1;
         end
         8'b1110????: begin
            partial_cp = CP_W'(b[3:0]);
            pend_count = 2'd2;
         end
         8'b11110???: begin
            partial_cp = CP_W'(b[2:0]);
            pend_count = 2'd3;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic int pick_gap_max();
      int pick;
      pick = $urandom_range(0, 2);
      return (pick == 0) ? 0 : (pick == 1) ? 3 : 14;
   endfunction

   task automatic report_mismatch(input string what, input logic [CP_W-1:0] got,
                                  input logic [CP_W-1:0] want);
      $display("MISMATCH at %0t: %s: got 0x%06h, expected 0x%06h", $realtime, what, got, want);
      error_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_text_byte(input logic [BYTE_W-1:0] b, input logic typed,
                                 input logic emits, input logic [CP_W-1:0] cp);
      int gap;
      logic [CP_W-1:0] predicted;
      bit has_result;
      bit ignored;
      gap = $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ignored = (pend_count == 0) &&
                (b == TERMINATOR || b[7:6] == 2'b10 || b[7:3] == 5'b11111);
      has_result = decode_text_byte(b, predicted);
      if (typed) begin
         if (emits) expected_code_points = {expected_code_points, cp};
      end else if (has_result) begin
         expected_code_points = {expected_code_points, predicted};
      end
      bytes_sent++;
      if (!ignored) decoded_items++;
      @(negedge clock);
   endtask

   // Mostly well-formed sequences with random payload; some truncated ones, lone terminators and raw noise.
   task automatic send_random_text();
      int kind;
      int len;
      int keep;
      logic [BYTE_W-1:0] lead;
      logic [BYTE_W-1:0] follow;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         send_text_byte(8'($urandom_range(1, 127)), 1'b0, 1'b0, '0);
      end else if (kind >= 78 && kind < 84) begin
         send_text_byte(TERMINATOR, 1'b0, 1'b0, '0);
      end else if (kind >= 90) begin
         send_text_byte(8'($urandom), 1'b0, 1'b0, '0);
      end else begin
         len = (kind < 50) ? 2 : (kind < 65) ? 3 : (kind < 78) ? 4 : $urandom_range(2, 4);
         case (len)
            2: lead = {3'b110, 5'($urandom)};
            3: lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
         endcase
         keep = (kind >= 84) ? $urandom_range(0, len - 2) : len - 1;
         send_text_byte(lead, 1'b0, 1'b0, '0);
         repeat (keep) begin
            follow = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                 : {2'b10, 6'($urandom)};
            send_text_byte(follow, 1'b0, 1'b0, '0);
         end
         if (kind >= 84 && $urandom_range(0, 1) == 1) begin
            send_text_byte(TERMINATOR, 1'b0, 1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_cycles_left > 0) hold_cycles_left--;
   end

   always @(negedge clock) begin
      if (hold_cycles_left > 0) begin
         rsp_stall <= 1'b1;
      end else if (result_wait_left > 0) begin
         rsp_stall <= 1'b1;
         result_wait_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall === 1'b1) input_stall_cycles++;
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_code_points.size() == 0) begin
               report_mismatch("code point with none expected", rsp_code_point, '0);
            end else begin
               if (rsp_code_point !== expected_code_points[0]) begin
                  report_mismatch("code_point", rsp_code_point, expected_code_points[0]);
               end
               void'(expected_code_points.pop_front());
            end
            code_points_checked++;
            result_wait_left = $urandom_range(0, rsp_gap_max);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_text_byte = '0;
      rsp_stall = 1'b0;
      pend_count = '0;
      partial_cp = '0;
      error_count = 0;
      bytes_sent = 0;
      decoded_items = 0;
      code_points_checked = 0;
      input_stall_cycles = 0;
      result_wait_left = 0;
      hold_cycles_left = 0;
      sender_gap_max = 14;
      rsp_gap_max = 14;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_text_byte(DIRECTED_ROWS[i].text_byte, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].emits, DIRECTED_ROWS[i].code_point);
      end

      // Let every code point drain before the back-pressure test.
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_code_points.size() != 0) @(negedge clock);

      // The receiver holds off for a long stretch while bytes keep coming back to back,
      // so the decoder fills up and stalls its input.
      hold_cycles_left = LONG_HOLD;
      sender_gap_max = 0;
      rsp_gap_max = 0;
      decoded_items = 0;
      while (decoded_items < RANDOM_ITEMS) begin
         if (hold_cycles_left == 0 && $urandom_range(0, 39) == 0) begin
            sender_gap_max = pick_gap_max();
            rsp_gap_max = pick_gap_max();
         end
         send_random_text();
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_code_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d text bytes (%0d random ones decoded), checked %0d code points.",
               bytes_sent, decoded_items, code_points_checked);
      $display("Input was held off for %0d cycles; %0d mismatches.",
               input_stall_cycles, error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
src/u8dec_pkg.sv
src/utf8_stream_decoder_unit.sv
tb/utf8_stream_decoder_unit_test.sv
